// File: sv/attribute_bitmap_pixel_codec_assert.svh
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ATTRIBUTE_BITMAP_PIXEL_CODEC_ASSERT_SVH
`define ATTRIBUTE_BITMAP_PIXEL_CODEC_ASSERT_SVH

// checked only outside reset
`define ABPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ABPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/abpc_pkg.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec package
// Field widths, command codes, internal job format and back-end states.
// ----------------------------------------------------------------------------
package abpc_pkg;

  localparam int CMD_W    = 2;
  localparam int X_W      = 7;
  localparam int Y_W      = 7;
  localparam int COLOR_W  = 5;
  localparam int ADDR_W   = 13;
  localparam int BYTE_W   = 8;

  localparam int FRAME_DEPTH_DEF = 8192;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int ROW_BYTES  = 80;
  localparam int LINE_BYTES = 40;
  localparam int MAX_X      = 116;
  localparam int MAX_Y      = 99;

  localparam logic [CMD_W-1:0] CMD_SET_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET_PIXEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_RAW = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ_RAW  = 2'd3;

  typedef enum logic [2:0] {
    OP_SET,
    OP_GET,
    OP_WRITE,
    OP_READ,
    OP_ZERO
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        xm;
    logic [1:0]        up_hi;
    logic [1:0]        lo_hi;
    logic [1:0]        fu;
    logic [1:0]        fl;
    logic [BYTE_W-1:0] data;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic empty;
    logic full;
    job_t head;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RD_UP,
    BK_RD_LO,
    BK_WR_LO,
    BK_OUT
  } bk_state_t;

endpackage

// File: sv/abpc_if.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface abpc_in_if;
  import abpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [X_W-1:0]     pixel_x;
  logic [Y_W-1:0]     pixel_y;
  logic [COLOR_W-1:0] color;
  logic [ADDR_W-1:0]  byte_addr;
  logic [BYTE_W-1:0]  byte_data;

  modport source (output valid, cmd, pixel_x, pixel_y, color, byte_addr, byte_data,
                  input ready);
  modport sink   (input valid, cmd, pixel_x, pixel_y, color, byte_addr, byte_data,
                  output ready);
endinterface

interface abpc_out_if;
  import abpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic [BYTE_W-1:0]  raw_byte;

  modport source (output valid, pixel_color, raw_byte, input ready);
  modport sink   (input valid, pixel_color, raw_byte, output ready);
endinterface

// File: sv/abpc_front.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec front end
// Accepts requests, range-checks them, works out the frame address and the
// encoded fields, and pushes a job into the queue.
// ----------------------------------------------------------------------------
module abpc_front #(
  parameter int FRAME_DEPTH = abpc_pkg::FRAME_DEPTH_DEF
) (
  abpc_in_if.sink            in_chan,
  input  abpc_pkg::q_stat_t  q_stat,
  output abpc_pkg::push_t    push_o
);
  import abpc_pkg::*;

  logic [X_W+8-1:0]    x_prod;
  logic [5:0]          x_div3;
  logic [1:0]          x_mod3;
  logic [ADDR_W-1:0]   pix_addr;
  logic                pix_inside;
  logic                raw_ok;
  logic [COLOR_W+3:0]  c_prod;
  logic [2:0]          grp;
  logic [2:0]          pat;
  logic                keep;
  job_t                job;

  // x/3 by reciprocal: exact for every 7-bit value
  assign x_prod = (X_W+8)'(in_chan.pixel_x) * (X_W+8)'(171);
  assign x_div3 = x_prod[14:9];
  assign x_mod3 = 2'(in_chan.pixel_x - 7'(x_div3) * 7'd3);

  assign pix_addr = (ADDR_W'(in_chan.pixel_y) << 6) + (ADDR_W'(in_chan.pixel_y) << 4)
                  + ADDR_W'(x_div3) + ADDR_W'(1);

  assign pix_inside = (in_chan.pixel_x <= X_W'(MAX_X)) && (in_chan.pixel_y <= Y_W'(MAX_Y));
  assign raw_ok     = {1'b0, in_chan.byte_addr} < (ADDR_W+1)'(FRAME_DEPTH);

  // color/5 by reciprocal, then the pattern is the remainder
  assign c_prod = (COLOR_W+4)'(in_chan.color) * (COLOR_W+4)'(13);
  assign grp    = c_prod[8:6];
  assign pat    = 3'(in_chan.color - 5'(grp) * 5'd5);

  always_comb begin
    job       = '0;
    job.op    = OP_ZERO;
    job.addr  = pix_addr;
    job.xm    = x_mod3;
    job.data  = in_chan.byte_data;
    keep      = 1'b1;
    if (grp <= 3'd3) begin
      job.up_hi = grp[0] ? 2'b11 : 2'b01;
      job.lo_hi = grp[1] ? 2'b11 : 2'b01;
    end
    case (pat)
      3'd1:    begin job.fu = 2'd2; job.fl = 2'd1; end
      3'd2:    begin job.fu = 2'd3; job.fl = 2'd0; end
      3'd3:    begin job.fu = 2'd0; job.fl = 2'd3; end
      3'd4:    begin job.fu = 2'd3; job.fl = 2'd3; end
      default: begin job.fu = 2'd0; job.fl = 2'd0; end
    endcase
    case (in_chan.cmd)
      CMD_SET_PIXEL: begin
        job.op = OP_SET;
        keep   = pix_inside;
      end
      CMD_GET_PIXEL: job.op = pix_inside ? OP_GET : OP_ZERO;
      CMD_WRITE_RAW: begin
        job.op   = OP_WRITE;
        job.addr = in_chan.byte_addr;
        keep     = raw_ok;
      end
      CMD_READ_RAW: begin
        job.op   = raw_ok ? OP_READ : OP_ZERO;
        job.addr = in_chan.byte_addr;
      end
      default: job.op = OP_ZERO;
    endcase
  end

  assign in_chan.ready = !q_stat.full;
  assign push_o.push   = in_chan.valid && !q_stat.full && keep;
  assign push_o.job    = job;

endmodule

// File: sv/abpc_queue.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec job queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
module abpc_queue #(
  parameter int QUEUE_DEPTH = abpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  abpc_pkg::push_t    push_i,
  input  logic               pop,
  output abpc_pkg::q_stat_t  q_stat
);
  import abpc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_stat.head  = slot_r[rd_ptr_r];

  assign do_push = push_i.push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_i.job;
    end
  end

endmodule

// File: sv/abpc_back.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec back end
// Frame memory and its access sequencer; read-modify-write of the two
// bytes behind a pixel, raw accesses and the result register.
// ----------------------------------------------------------------------------
module abpc_back #(
  parameter int FRAME_DEPTH = abpc_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  abpc_pkg::q_stat_t  q_stat,
  output logic               pop,
  abpc_out_if.source         out_chan
);
  import abpc_pkg::*;

  bk_state_t         state_r, state_nxt;
  job_t              cur_r;
  logic [BYTE_W-1:0] up_r;
  logic [BYTE_W-1:0] lo_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];

  logic              out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] out_pix_r, out_pix_nxt;
  logic [BYTE_W-1:0] out_raw_r, out_raw_nxt;

  logic [ADDR_W-1:0] lo_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic              load_out;
  logic [COLOR_W-1:0] res_pix;
  logic [BYTE_W-1:0] res_raw;

  function automatic logic [BYTE_W-1:0] merge_field(input logic [BYTE_W-1:0] old,
                                                    input logic [1:0] hi,
                                                    input logic [1:0] fld,
                                                    input logic [1:0] xm);
    logic [BYTE_W-1:0] nb;
    nb = {hi, old[5:0]};
    case (xm)
      2'd0:    nb[5:4] = fld;
      2'd1:    nb[3:2] = fld;
      default: nb[1:0] = fld;
    endcase
    return nb;
  endfunction

  function automatic logic [1:0] pick_field(input logic [BYTE_W-1:0] b,
                                            input logic [1:0] xm);
    logic [1:0] f;
    case (xm)
      2'd0:    f = b[5:4];
      2'd1:    f = b[3:2];
      default: f = b[1:0];
    endcase
    return f;
  endfunction

  function automatic logic [COLOR_W-1:0] decode_color(input logic [BYTE_W-1:0] up,
                                                      input logic [BYTE_W-1:0] lo,
                                                      input logic [1:0] xm);
    logic [1:0]         fu;
    logic [1:0]         fl;
    logic [COLOR_W-1:0] c;
    fu = pick_field(up, xm);
    fl = pick_field(lo, xm);
    c  = (up[7] ? 5'd5 : 5'd0) + (lo[7] ? 5'd10 : 5'd0);
    case (fu)
      2'd0:    c = c + ((fl == 2'd3) ? 5'd3 : 5'd0);
      2'd2:    c = c + 5'd1;
      2'd3:    c = c + ((fl == 2'd3) ? 5'd4 : 5'd2);
      default: c = c;
    endcase
    return c;
  endfunction

  assign lo_addr  = cur_r.addr + ADDR_W'(LINE_BYTES);
  assign load_out = (state_r == BK_OUT) && (!out_valid_r || out_chan.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          case (q_stat.head.op)
            OP_SET, OP_GET, OP_READ: state_nxt = BK_RD_UP;
            OP_ZERO:                 state_nxt = BK_OUT;
            default:                 state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_RD_UP: state_nxt = (cur_r.op == OP_READ) ? BK_OUT : BK_RD_LO;
      BK_RD_LO: state_nxt = (cur_r.op == OP_SET) ? BK_WR_LO : BK_OUT;
      BK_WR_LO: state_nxt = BK_IDLE;
      BK_OUT:   state_nxt = load_out ? BK_IDLE : BK_OUT;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // memory controls per state
  always_comb begin
    pop     = 1'b0;
    rd_addr = cur_r.addr;
    mem_we  = 1'b0;
    mem_wa  = cur_r.addr;
    mem_wd  = q_stat.head.data;
    case (state_r)
      BK_IDLE: begin
        pop     = !q_stat.empty;
        rd_addr = q_stat.head.addr;
        mem_we  = !q_stat.empty && (q_stat.head.op == OP_WRITE);
        mem_wa  = q_stat.head.addr;
      end
      BK_RD_UP: rd_addr = lo_addr;
      BK_RD_LO: begin
        mem_we = (cur_r.op == OP_SET);
        mem_wd = merge_field(up_r, cur_r.up_hi, cur_r.fu, cur_r.xm);
      end
      BK_WR_LO: begin
        mem_we = 1'b1;
        mem_wa = lo_addr;
        mem_wd = merge_field(lo_r, cur_r.lo_hi, cur_r.fl, cur_r.xm);
      end
      default: ;
    endcase
  end

  // result formatting
  always_comb begin
    res_pix = '0;
    res_raw = '0;
    case (cur_r.op)
      OP_GET:  res_pix = decode_color(up_r, lo_r, cur_r.xm);
      OP_READ: res_raw = up_r;
      default: ;
    endcase
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_raw_nxt   = out_raw_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_pix_nxt   = res_pix;
      out_raw_nxt   = res_raw;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r <= out_pix_nxt;
    out_raw_r <= out_raw_nxt;
    if (pop) begin
      cur_r <= q_stat.head;
    end
    if (state_r == BK_RD_UP) begin
      up_r <= rd_data_r;
    end
    if (state_r == BK_RD_LO) begin
      lo_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= frame_mem[rd_addr];
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_color = out_pix_r;
  assign out_chan.raw_byte    = out_raw_r;

endmodule

// File: sv/attribute_bitmap_pixel_codec.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec
// Pixel set/get and raw byte access over a 40-byte-per-line attribute bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one request per handshake: set pixel, get pixel, write raw
//   byte or read raw byte. Get pixel and read raw byte each return exactly one
//   result on out_chan; set pixel and raw write return nothing.
//   Requests land in a four-deep job queue, so in_chan keeps taking requests
//   while the back end is busy or a result waits for out_chan.ready.
//   Back-end steps per request, set by the frame memory's one read and one
//   write port: set pixel reads upper, reads lower, writes upper and writes
//   lower; get pixel reads upper and lower; raw read reads its byte; raw
//   write writes its byte from the queue head; out-of-range get or read
//   goes straight to the output. The back end takes one request at a time.
//   Out-of-range set pixel and raw write are dropped at the front.
//   A stalled out_chan holds its result; the back end then waits and the
//   queue fills until in_chan.ready drops.
//   Reset (rst_n low, synchronous) empties the queue and the output register;
//   the frame memory is not cleared and must be written before it is read.
// ----------------------------------------------------------------------------
module attribute_bitmap_pixel_codec #(
  parameter int FRAME_DEPTH = abpc_pkg::FRAME_DEPTH_DEF,
  parameter int QUEUE_DEPTH = abpc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  abpc_in_if.sink     in_chan,
  abpc_out_if.source  out_chan
);
  import abpc_pkg::*;

  push_t   push;
  q_stat_t q_stat;
  logic    pop;

  abpc_front #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_front (
    .in_chan (in_chan),
    .q_stat  (q_stat),
    .push_o  (push)
  );

  abpc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .q_stat (q_stat)
  );

  abpc_back #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

// File: sv/abpc_checker.sv
// ----------------------------------------------------------------------------
// Attribute bitmap pixel codec port checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "attribute_bitmap_pixel_codec_assert.svh"

module abpc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] pixel_color,
  input logic [7:0] raw_byte
);

  // result held until taken
  `ABPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  `ABPC_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(pixel_color) && $stable(raw_byte), "stalled result changed")

  // a result is either a pixel or a raw byte, never both
  `ABPC_ASSERT(a_one_kind, clk, rst_n, out_valid && (pixel_color != 5'd0) |-> raw_byte == 8'd0, "pixel and raw fields both set")

  // decoder tops out at group 3, pattern 4
  `ABPC_ASSERT(a_color_range, clk, rst_n, out_valid |-> pixel_color <= 5'd19, "decoded colour out of range")

  `ABPC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind attribute_bitmap_pixel_codec abpc_checker u_abpc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pixel_color (out_chan.pixel_color),
  .raw_byte    (out_chan.raw_byte)
);
